>>> sv/assert_macros.svh
// Assertion helper macros shared by the beam power RTL.
// Stand-alone header; every use gets its own line in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check: prop must hold at every clock edge outside reset.
`define ASRT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Forbidden condition: cond must never be true outside reset.
`define ASRT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASRT_PROP(lbl, clk, rst, prop, msg)

`define ASRT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> sv/pab_pkg.sv
// Shared types and constants for the phased array beam power block.
// No dependencies; used by pab_power and phased_array_beam_power.
`timescale 1ns / 1ps
`default_nettype none

package pab_pkg;

   // Parameter defaults
   localparam int NUM_ANTENNAS_DEF       = 96;
   localparam int WEIGHT_GROUPS_DEF      = 48;
   localparam int CHANNELS_PER_GROUP_DEF = 8;
   localparam int NUM_CHANNELS_DEF       = 384;

   // Field widths
   localparam int ANT_W    = 6;
   localparam int CHAN_W   = 9;
   localparam int SAMPLE_W = 8;
   localparam int NIB_W    = 4;
   localparam int WEIGHT_W = 16;
   localparam int POWER_W  = 8;

   // Datapath widths
   localparam int PROD_W = NIB_W + WEIGHT_W;   // nibble times weight
   localparam int TERM_W = PROD_W + 1;         // sum of two products
   localparam int SQ_W   = 2 * PROD_W;         // squared product
   localparam int INC_W  = 2 * PROD_W - 1;     // sum of four squared products
   localparam int ACC_W  = 28;                 // coherent accumulators
   localparam int WIDE_W = 48;                 // incoherent accumulator
   localparam int PWR_W  = 2 * ACC_W + 1;      // power numerator

   // Power unit sequencing
   localparam int CNT_W = 2;
   localparam logic [CNT_W-1:0] SQ_LAST = 2'd3;

   // Item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_WEIGHT = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INCOH_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_SELECT = 1'd1;

   typedef enum logic [1:0] {
      PWR_IDLE,
      PWR_SQUARE,
      PWR_DIVIDE,
      PWR_HOLD
   } pwr_state_type;

   // Start command from the accumulator to the power unit
   typedef struct packed {
      logic              start;
      logic              incoherent;
      logic [CHAN_W-1:0] channel;
   } pwr_cmd_type;

endpackage

`default_nettype wire

>>> sv/phased_array_beam_power.sv
// Beam power: 4-bit dual-pol samples times stored weights, summed over one arm.
// Weights and samples transfer one per cycle while req_ready is high; samples pass
// a three-stage pipe into the sums. For a last-antenna sample the coherent sums are
// squared in turn on a shared multiplier and then scaled (incoherent mode skips the
// squaring); input stalls until that sample's result sits in the output register.
// Synchronous reset clears control, accumulators and CSRs; weights stay undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module phased_array_beam_power #(
   parameter int NUM_ANTENNAS       = pab_pkg::NUM_ANTENNAS_DEF,
   parameter int WEIGHT_GROUPS      = pab_pkg::WEIGHT_GROUPS_DEF,
   parameter int CHANNELS_PER_GROUP = pab_pkg::CHANNELS_PER_GROUP_DEF,
   parameter int NUM_CHANNELS       = pab_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pab_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic                                csr_wdata,
   // input items
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_op,
   input  wire logic                                req_weight_arm,
   input  wire logic [pab_pkg::ANT_W-1:0]           req_antenna,
   input  wire logic [pab_pkg::CHAN_W-1:0]          req_channel,
   input  wire logic [pab_pkg::SAMPLE_W-1:0]        req_sample_x,
   input  wire logic [pab_pkg::SAMPLE_W-1:0]        req_sample_y,
   input  wire logic                                req_last_antenna,
   input  wire logic                                req_weight_pol,
   input  wire logic signed [pab_pkg::WEIGHT_W-1:0] req_weight_re,
   input  wire logic signed [pab_pkg::WEIGHT_W-1:0] req_weight_im,
   // results
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [pab_pkg::CHAN_W-1:0]               rsp_out_channel,
   output logic [pab_pkg::POWER_W-1:0]              rsp_beam_power,
   output logic                                     rsp_saturated
);

   localparam int ARM_SIZE  = NUM_ANTENNAS / 2;
   localparam int MEM_DEPTH = NUM_ANTENNAS * WEIGHT_GROUPS;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int GRP_SH    = pab_pkg::CHAN_W + $clog2(CHANNELS_PER_GROUP);
   localparam int GRP_RECIP = ((1 << GRP_SH) + CHANNELS_PER_GROUP - 1) / CHANNELS_PER_GROUP;
   localparam int WW        = 2 * pab_pkg::WEIGHT_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic incoh_ff;
   logic arm_sel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         incoh_ff   <= 1'b0;
         arm_sel_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pab_pkg::CSR_INCOH_MODE: incoh_ff   <= csr_wdata;
            pab_pkg::CSR_ARM_SELECT: arm_sel_ff <= csr_wdata;
            default:                 incoh_ff   <= incoh_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Weight address: arm, antenna, channel group
   // ------------------------------------------------------------------
   logic          req_xfer;
   logic          arm_sel;
   logic [31:0]   grp_full;
   logic          hit;
   logic [AW-1:0] addr;

   assign req_xfer = req_valid && req_ready;
   assign arm_sel  = (req_op == pab_pkg::OP_WEIGHT) ? req_weight_arm : arm_sel_ff;
   // channel / CHANNELS_PER_GROUP by reciprocal multiply
   assign grp_full = (32'(req_channel) * 32'(GRP_RECIP)) >> GRP_SH;
   assign hit      = (32'(req_antenna) < 32'(ARM_SIZE)) &&
                     (32'(req_channel) < 32'(NUM_CHANNELS)) &&
                     (grp_full < 32'(WEIGHT_GROUPS));
   assign addr     = AW'((32'(arm_sel) * 32'(ARM_SIZE) + 32'(req_antenna))
                         * 32'(WEIGHT_GROUPS) + grp_full);

   // ------------------------------------------------------------------
   // Weight memories, one per polarization: {imag, real}
   // ------------------------------------------------------------------
   logic [WW-1:0] wmem_x [MEM_DEPTH];
   logic [WW-1:0] wmem_y [MEM_DEPTH];
   logic [WW-1:0] rd_x_ff;
   logic [WW-1:0] rd_y_ff;
   logic          wr_en;

   assign wr_en = req_xfer && (req_op == pab_pkg::OP_WEIGHT) && hit;

   always_ff @(posedge clock) begin
      if (wr_en && !req_weight_pol) begin
         wmem_x[addr] <= {req_weight_im, req_weight_re};
      end
      if (req_xfer && (req_op == pab_pkg::OP_SAMPLE)) begin
         rd_x_ff <= wmem_x[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && req_weight_pol) begin
         wmem_y[addr] <= {req_weight_im, req_weight_re};
      end
      if (req_xfer && (req_op == pab_pkg::OP_SAMPLE)) begin
         rd_y_ff <= wmem_y[addr];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: sample beside its read data
   // ------------------------------------------------------------------
   logic                           st1_valid_ff;
   logic                           st1_last_ff;
   logic                           st1_hit_ff;
   logic [pab_pkg::CHAN_W-1:0]     st1_chan_ff;
   logic [pab_pkg::SAMPLE_W-1:0]   st1_sx_ff;
   logic [pab_pkg::SAMPLE_W-1:0]   st1_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= req_xfer && (req_op == pab_pkg::OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      st1_last_ff <= req_last_antenna;
      st1_hit_ff  <= hit;
      st1_chan_ff <= req_channel;
      st1_sx_ff   <= req_sample_x;
      st1_sy_ff   <= req_sample_y;
   end

   // Products; index: 0 xr*wrx, 1 xi*wix, 2 xr*wix, 3 xi*wrx,
   // 4 yr*wry, 5 yi*wiy, 6 yr*wiy, 7 yi*wry
   logic signed [pab_pkg::NIB_W-1:0]    xr, xi, yr, yi;
   logic signed [pab_pkg::WEIGHT_W-1:0] wrx, wix, wry, wiy;
   logic signed [pab_pkg::PROD_W-1:0]   p_in [8];

   always_comb begin
      xr  = st1_sx_ff[pab_pkg::NIB_W-1:0];
      xi  = st1_sx_ff[pab_pkg::SAMPLE_W-1:pab_pkg::NIB_W];
      yr  = st1_sy_ff[pab_pkg::NIB_W-1:0];
      yi  = st1_sy_ff[pab_pkg::SAMPLE_W-1:pab_pkg::NIB_W];
      // out-of-range lookups use a zero weight
      wrx = st1_hit_ff ? rd_x_ff[pab_pkg::WEIGHT_W-1:0] : '0;
      wix = st1_hit_ff ? rd_x_ff[WW-1:pab_pkg::WEIGHT_W] : '0;
      wry = st1_hit_ff ? rd_y_ff[pab_pkg::WEIGHT_W-1:0] : '0;
      wiy = st1_hit_ff ? rd_y_ff[WW-1:pab_pkg::WEIGHT_W] : '0;
      p_in[0] = xr * wrx;
      p_in[1] = xi * wix;
      p_in[2] = xr * wix;
      p_in[3] = xi * wrx;
      p_in[4] = yr * wry;
      p_in[5] = yi * wiy;
      p_in[6] = yr * wiy;
      p_in[7] = yi * wry;
   end

   // ------------------------------------------------------------------
   // Stage 2: products
   // ------------------------------------------------------------------
   logic                              st2_valid_ff;
   logic                              st2_last_ff;
   logic [pab_pkg::CHAN_W-1:0]        st2_chan_ff;
   logic signed [pab_pkg::PROD_W-1:0] p_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else begin
         st2_valid_ff <= st1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st2_last_ff <= st1_last_ff;
      st2_chan_ff <= st1_chan_ff;
      for (int i = 0; i < 8; i++) begin
         p_ff[i] <= p_in[i];
      end
   end

   // Coherent terms and incoherent squared sum
   logic signed [pab_pkg::TERM_W-1:0] term_in [4];
   logic signed [pab_pkg::SQ_W-1:0]   isq [4];
   logic [pab_pkg::INC_W-1:0]         inc_in;

   always_comb begin
      term_in[0] = pab_pkg::TERM_W'(p_ff[0]) - pab_pkg::TERM_W'(p_ff[1]);
      term_in[1] = pab_pkg::TERM_W'(p_ff[2]) + pab_pkg::TERM_W'(p_ff[3]);
      term_in[2] = pab_pkg::TERM_W'(p_ff[4]) - pab_pkg::TERM_W'(p_ff[5]);
      term_in[3] = pab_pkg::TERM_W'(p_ff[6]) + pab_pkg::TERM_W'(p_ff[7]);
      isq[0] = p_ff[0] * p_ff[0];
      isq[1] = p_ff[1] * p_ff[1];
      isq[2] = p_ff[4] * p_ff[4];
      isq[3] = p_ff[5] * p_ff[5];
      inc_in = pab_pkg::INC_W'($unsigned(isq[0])) + pab_pkg::INC_W'($unsigned(isq[1]))
             + pab_pkg::INC_W'($unsigned(isq[2])) + pab_pkg::INC_W'($unsigned(isq[3]));
   end

   // ------------------------------------------------------------------
   // Stage 3: terms
   // ------------------------------------------------------------------
   logic                              st3_valid_ff;
   logic                              st3_last_ff;
   logic [pab_pkg::CHAN_W-1:0]        st3_chan_ff;
   logic signed [pab_pkg::TERM_W-1:0] term_ff [4];
   logic [pab_pkg::INC_W-1:0]         inc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end else begin
         st3_valid_ff <= st2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st3_last_ff <= st2_last_ff;
      st3_chan_ff <= st2_chan_ff;
      inc_ff      <= inc_in;
      for (int i = 0; i < 4; i++) begin
         term_ff[i] <= term_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Accumulate; a last sample hands the sums to the power unit and clears
   // ------------------------------------------------------------------
   logic [pab_pkg::WIDE_W-1:0]       acc_xr_ff, acc_xr_in;
   logic signed [pab_pkg::ACC_W-1:0] acc_xi_ff, acc_xi_in;
   logic signed [pab_pkg::ACC_W-1:0] acc_yr_ff, acc_yr_in;
   logic signed [pab_pkg::ACC_W-1:0] acc_yi_ff, acc_yi_in;
   logic [pab_pkg::ACC_W-1:0]        xr_low;
   logic                             st3_end;

   assign st3_end = st3_valid_ff && st3_last_ff;

   always_comb begin
      acc_xr_in = acc_xr_ff;
      acc_xi_in = acc_xi_ff;
      acc_yr_in = acc_yr_ff;
      acc_yi_in = acc_yi_ff;
      xr_low    = acc_xr_ff[pab_pkg::ACC_W-1:0] + pab_pkg::ACC_W'(term_ff[0]);
      if (st3_valid_ff) begin
         if (incoh_ff) begin
            acc_xr_in = acc_xr_ff + pab_pkg::WIDE_W'(inc_ff);
         end else begin
            acc_xr_in = pab_pkg::WIDE_W'(xr_low);
            acc_xi_in = acc_xi_ff + pab_pkg::ACC_W'(term_ff[1]);
            acc_yr_in = acc_yr_ff + pab_pkg::ACC_W'(term_ff[2]);
            acc_yi_in = acc_yi_ff + pab_pkg::ACC_W'(term_ff[3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || st3_end) begin
         acc_xr_ff <= '0;
         acc_xi_ff <= '0;
         acc_yr_ff <= '0;
         acc_yi_ff <= '0;
      end else begin
         acc_xr_ff <= acc_xr_in;
         acc_xi_ff <= acc_xi_in;
         acc_yr_ff <= acc_yr_in;
         acc_yi_ff <= acc_yi_in;
      end
   end

   // ------------------------------------------------------------------
   // Power unit and output register
   // ------------------------------------------------------------------
   pab_pkg::pwr_cmd_type pwr_cmd;
   logic                 pwr_busy;

   always_comb begin
      pwr_cmd.start      = st3_end;
      pwr_cmd.incoherent = incoh_ff;
      pwr_cmd.channel    = st3_chan_ff;
   end

   pab_power #(
      .NUM_ANTENNAS (NUM_ANTENNAS)
   ) u_power (
      .clock           (clock),
      .reset           (reset),
      .cmd             (pwr_cmd),
      .acc_wide        (acc_xr_in),
      .acc_xi          (acc_xi_in),
      .acc_yr          (acc_yr_in),
      .acc_yi          (acc_yi_in),
      .busy            (pwr_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_beam_power  (rsp_beam_power),
      .rsp_saturated   (rsp_saturated)
   );

   // Hold input while a last sample or its power computation is in flight
   logic       last_in_flight;
   logic [3:0] last_stage;
   logic       acc_zero;

   assign last_stage     = {st1_valid_ff && st1_last_ff, st2_valid_ff && st2_last_ff,
                            st3_end, pwr_busy};
   assign last_in_flight = |last_stage;
   assign req_ready      = !last_in_flight;
   assign acc_zero       = (acc_xr_ff == '0) && (acc_xi_ff == '0) && (acc_yr_ff == '0)
                        && (acc_yi_ff == '0);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASRT_PROP(a_one_last, clock, reset, $countones(last_stage) <= 1, "two beam sums in flight")
   `ASRT_PROP(a_start_busy, clock, reset, st3_end |=> pwr_busy, "power unit missed a sum")
   `ASRT_PROP(a_acc_clear, clock, reset, st3_end |=> acc_zero, "sums not cleared after last")

endmodule

`default_nettype wire

>>> sv/pab_power.sv
// Power unit: squares coherent beam sums on one shared multiplier, scales by a
// reciprocal multiply against the fixed divisor and holds the result transfer.
// Depends on pab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pab_power #(
   parameter int NUM_ANTENNAS = pab_pkg::NUM_ANTENNAS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pab_pkg::pwr_cmd_type            cmd,
   input  wire logic [pab_pkg::WIDE_W-1:0]      acc_wide,
   input  wire logic signed [pab_pkg::ACC_W-1:0] acc_xi,
   input  wire logic signed [pab_pkg::ACC_W-1:0] acc_yr,
   input  wire logic signed [pab_pkg::ACC_W-1:0] acc_yi,
   output logic                                 busy,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pab_pkg::CHAN_W-1:0]           rsp_out_channel,
   output logic [pab_pkg::POWER_W-1:0]          rsp_beam_power,
   output logic                                 rsp_saturated
);

   // Divisor 2^17 * N^2: shift off the 2^17, then divide by N^2 with a
   // reciprocal that is exact for every quotient below 256
   localparam int               SCALE_SH = 17;
   localparam int               HI_W     = pab_pkg::PWR_W - SCALE_SH;
   localparam longint unsigned  ANT_SQ   = 64'(NUM_ANTENNAS) * 64'(NUM_ANTENNAS);
   localparam int               ANT_SQ_W = $clog2(ANT_SQ);
   localparam int               LOW_W    = pab_pkg::POWER_W + ANT_SQ_W;
   localparam int               RCP_W    = LOW_W + 2;
   localparam int               QP_W     = LOW_W + RCP_W;
   localparam int               RCP_SH   = pab_pkg::POWER_W + 2 * ANT_SQ_W;
   localparam longint unsigned  RCP_FULL = ((64'd1 << RCP_SH) + ANT_SQ - 64'd1) / ANT_SQ;
   localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_FULL);
   localparam logic [HI_W-1:0]  SAT_LIM  = HI_W'(ANT_SQ << pab_pkg::POWER_W);

   pab_pkg::pwr_state_type state_ff, state_in;

   logic signed [pab_pkg::ACC_W-1:0]   sum_ff [4];
   logic [pab_pkg::PWR_W-1:0]          num_ff;
   logic [pab_pkg::CNT_W-1:0]          cnt_ff;
   logic [pab_pkg::POWER_W-1:0]        q_ff;
   logic                               sat_ff;
   logic [pab_pkg::CHAN_W-1:0]         chan_ff;

   logic                               rsp_valid_ff;
   logic [pab_pkg::CHAN_W-1:0]         rsp_chan_ff;
   logic [pab_pkg::POWER_W-1:0]        rsp_power_ff;
   logic                               rsp_sat_ff;

   logic signed [2*pab_pkg::ACC_W-1:0] sq;
   logic [HI_W-1:0]                    num_hi;
   logic [QP_W-1:0]                    prod;
   logic                               over;
   logic [pab_pkg::POWER_W-1:0]        q_calc;
   logic                               slot_free;
   logic                               rsp_load;

   assign sq        = sum_ff[0] * sum_ff[0];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Scale: clip at 256 times the divisor, else multiply by the reciprocal
   assign num_hi = num_ff[pab_pkg::PWR_W-1:SCALE_SH];
   assign over   = (num_hi >= SAT_LIM);
   assign prod   = QP_W'(num_hi[LOW_W-1:0]) * QP_W'(RCP);
   assign q_calc = pab_pkg::POWER_W'(prod >> RCP_SH);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pab_pkg::PWR_IDLE: begin
            if (cmd.start) begin
               state_in = cmd.incoherent ? pab_pkg::PWR_DIVIDE : pab_pkg::PWR_SQUARE;
            end
         end
         pab_pkg::PWR_SQUARE: begin
            if (cnt_ff == pab_pkg::SQ_LAST) begin
               state_in = pab_pkg::PWR_DIVIDE;
            end
         end
         pab_pkg::PWR_DIVIDE: begin
            state_in = pab_pkg::PWR_HOLD;
         end
         pab_pkg::PWR_HOLD: begin
            if (slot_free) begin
               state_in = pab_pkg::PWR_IDLE;
            end
         end
         default: state_in = pab_pkg::PWR_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy     = 1'b1;
      rsp_load = 1'b0;
      unique case (state_ff)
         pab_pkg::PWR_IDLE:   busy = 1'b0;
         pab_pkg::PWR_SQUARE: busy = 1'b1;
         pab_pkg::PWR_DIVIDE: busy = 1'b1;
         pab_pkg::PWR_HOLD:   rsp_load = slot_free;
         default:             busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pab_pkg::PWR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Square, accumulate and scale
   always_ff @(posedge clock) begin
      unique case (state_ff)
         pab_pkg::PWR_IDLE: begin
            if (cmd.start) begin
               chan_ff   <= cmd.channel;
               sum_ff[0] <= acc_wide[pab_pkg::ACC_W-1:0];
               sum_ff[1] <= acc_xi;
               sum_ff[2] <= acc_yr;
               sum_ff[3] <= acc_yi;
               // incoherent sum is doubled to share the coherent divisor
               num_ff    <= cmd.incoherent ? pab_pkg::PWR_W'({acc_wide, 1'b0}) : '0;
               cnt_ff    <= '0;
            end
         end
         pab_pkg::PWR_SQUARE: begin
            num_ff <= num_ff + pab_pkg::PWR_W'($unsigned(sq));
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i+1];
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         pab_pkg::PWR_DIVIDE: begin
            // clip when the quotient would reach 256
            q_ff   <= over ? '1 : q_calc;
            sat_ff <= over;
         end
         pab_pkg::PWR_HOLD: begin
            cnt_ff <= cnt_ff;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   // Output register; hold until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chan_ff  <= chan_ff;
         rsp_power_ff <= q_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_beam_power  = rsp_power_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire
